// ===== rtl/sapq_pkg.sv =====
// Shared constants and types for the sorted array priority queue.
`default_nettype none
package sapq_pkg;

  localparam int QUEUE_DEPTH   = 16;
  localparam int VALUE_BITS    = 32;
  localparam int PRIORITY_BITS = 16;
  localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);

  // fixed port widths
  localparam int PORT_VALUE_W = 32;
  localparam int PORT_PRIO_W  = 16;
  localparam int TOTAL_W      = 5;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_PULL   = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [VALUE_BITS-1:0]    value;
    logic [PRIORITY_BITS-1:0] prio;
  } entry_t;

  // broadcast to every cell
  typedef struct packed {
    logic   ins_en;
    logic   pull_en;
    entry_t item;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/sapq_cell.sv =====
// One slot of the sorted array: holds an entry and trades it with its neighbors.
`default_nettype none
module sapq_cell
  import sapq_pkg::*;
(
  input  wire logic      clk_i,
  input  wire cell_ctl_t ctl_i,
  input  wire logic      occ_i,      // slot holds a live entry
  input  wire logic      at_tail_i,  // slot is the first free one
  input  wire entry_t    left_i,
  input  wire logic      left_lt_i,  // left neighbor is live and ranks below new item
  input  wire entry_t    right_i,
  output entry_t         entry_o,
  output entry_t         entry_d_o,
  output logic           lt_o
);

  entry_t entry_q, entry_d;

  assign lt_o = occ_i && ($signed(entry_q.prio) < $signed(ctl_i.item.prio));

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.ins_en) begin
      if (left_lt_i) begin
        entry_d = left_i;
      end else if (lt_o || at_tail_i) begin
        entry_d = ctl_i.item;
      end
    end else if (ctl_i.pull_en) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o   = entry_q;
  assign entry_d_o = entry_d;

endmodule
`default_nettype wire

// ===== rtl/sorted_array_priority_queue.sv =====
// Top level of the sorted array priority queue: cell row, count and result register.
//
// Bounded priority queue held in a row of QUEUE_DEPTH slot cells, highest
// priority in slot 0. Each input word is an insert (value plus signed
// priority) or a pull. An insert lands behind all entries of equal or higher
// priority, so ties leave in arrival order. Insert on full and pull on empty
// are rejected with a status code and change nothing.
// Both channels use valid/stall. One result word follows every input word,
// in the cycle after acceptance; every slot compares and shifts in parallel,
// so one word is taken each cycle unless the receiver stalls a held result.
// The result register frees as it is read: a new input word is taken in the
// same cycle the pending result leaves. While the receiver stalls a held
// result, in_stall_o is high and the queue state holds.
// Reset empties the queue at once (count cleared, no result pending); slot
// contents are not cleared and are never read while not live.
`default_nettype none
module sorted_array_priority_queue
  import sapq_pkg::*;
(
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          command_i,
  input  wire logic        [PORT_VALUE_W-1:0] item_value_i,
  input  wire logic signed [PORT_PRIO_W-1:0]  item_priority_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic             [PORT_VALUE_W-1:0] pulled_value_o,
  output logic                               pulled_valid_o,
  output logic             [1:0]              status_o,
  output logic             [PORT_VALUE_W-1:0] head_value_o,
  output logic             [TOTAL_W-1:0]      entry_total_o,
  output logic                               queue_empty_o,
  output logic                               queue_full_o
);

  logic             accept;
  logic             is_full, is_empty;
  cell_ctl_t        ctl;
  status_e          status_d;
  logic [CNT_W-1:0] count_q, count_d;

  entry_t entry   [QUEUE_DEPTH];
  entry_t entry_d [QUEUE_DEPTH];
  logic   lt      [QUEUE_DEPTH];

  logic                    out_valid_q;
  logic [VALUE_BITS-1:0]   pulled_value_q, head_value_q;
  logic                    pulled_valid_q, empty_q, full_q;
  status_e                 status_q;
  logic [CNT_W-1:0]        total_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_full    = (count_q == CNT_W'(QUEUE_DEPTH));
  assign is_empty   = (count_q == '0);

  always_comb begin
    ctl.ins_en     = accept && (command_i == CMD_INSERT) && !is_full;
    ctl.pull_en    = accept && (command_i == CMD_PULL) && !is_empty;
    ctl.item.value = VALUE_BITS'(item_value_i);
    ctl.item.prio  = PRIORITY_BITS'(item_priority_i);
  end

  always_comb begin
    count_d  = count_q;
    status_d = STATUS_OK;
    if (ctl.ins_en) begin
      count_d = count_q + CNT_W'(1);
    end else if (ctl.pull_en) begin
      count_d = count_q - CNT_W'(1);
    end
    if (command_i == CMD_INSERT) begin
      if (is_full) status_d = STATUS_FULL;
    end else begin
      if (is_empty) status_d = STATUS_EMPTY;
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t left_e, right_e;
    logic   left_lt;

    if (i == 0) begin : g_head
      assign left_e  = entry[0];
      assign left_lt = 1'b0;
    end else begin : g_mid
      assign left_e  = entry[i-1];
      assign left_lt = lt[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_e = entry[i];
    end else begin : g_inner
      assign right_e = entry[i+1];
    end

    sapq_cell u_cell (
      .clk_i     (clk_i),
      .ctl_i     (ctl),
      .occ_i     (count_q > CNT_W'(i)),
      .at_tail_i (count_q == CNT_W'(i)),
      .left_i    (left_e),
      .left_lt_i (left_lt),
      .right_i   (right_e),
      .entry_o   (entry[i]),
      .entry_d_o (entry_d[i]),
      .lt_o      (lt[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result word payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pulled_value_q <= ctl.pull_en ? entry[0].value : '0;
      pulled_valid_q <= ctl.pull_en;
      status_q       <= status_d;
      head_value_q   <= (count_d != '0) ? entry_d[0].value : '0;
      total_q        <= count_d;
      empty_q        <= (count_d == '0);
      full_q         <= (count_d == CNT_W'(QUEUE_DEPTH));
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pulled_value_o = PORT_VALUE_W'(pulled_value_q);
  assign pulled_valid_o = pulled_valid_q;
  assign status_o       = status_q;
  assign head_value_o   = PORT_VALUE_W'(head_value_q);
  assign entry_total_o  = TOTAL_W'(total_q);
  assign queue_empty_o  = empty_q;
  assign queue_full_o   = full_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count above depth");

  a_empty_pull: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && command_i == CMD_PULL && is_empty) |=>
      (out_valid_o && status_o == STATUS_EMPTY && !pulled_valid_o))
    else $error("pull on empty queue not rejected");

  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && command_i == CMD_INSERT && is_full) |=> $stable(count_q))
    else $error("rejected insert changed the count");

  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (queue_empty_o == (total_q == '0)
                     && (pulled_valid_o == (status_o == STATUS_OK
                                            && pulled_value_o == pulled_value_o)
                         || !pulled_valid_o)))
    else $error("result flags disagree with entry total");

endmodule
`default_nettype wire

// ===== verif/sapq_checker.sv =====
// Channel monitor for the priority queue: shadow queue, expected-result store and field compare.
`timescale 1ns / 1ps
module sapq_checker
  import sapq_pkg::*;
(
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  input  wire logic                          in_stall_i,
  input  wire logic                          command_i,
  input  wire logic        [PORT_VALUE_W-1:0] item_value_i,
  input  wire logic signed [PORT_PRIO_W-1:0]  item_priority_i,
  input  wire logic                          out_valid_i,
  input  wire logic                          out_stall_i,
  input  wire logic        [PORT_VALUE_W-1:0] pulled_value_i,
  input  wire logic                          pulled_valid_i,
  input  wire logic        [1:0]              status_i,
  input  wire logic        [PORT_VALUE_W-1:0] head_value_i,
  input  wire logic        [TOTAL_W-1:0]      entry_total_i,
  input  wire logic                          queue_empty_i,
  input  wire logic                          queue_full_i,
  output int                                 fail_count_o,
  output int                                 pending_o,
  output int                                 checked_o,
  output int                                 full_rejects_o,
  output int                                 empty_rejects_o
);

  typedef struct {
    logic [PORT_VALUE_W-1:0] pulled_value;
    logic                    pulled_valid;
    status_e                 status;
    logic [PORT_VALUE_W-1:0] head_value;
    logic [TOTAL_W-1:0]      entry_total;
    logic                    queue_empty;
    logic                    queue_full;
  } queue_result_t;

  // shadow of the sorted slots, head in index 0
  logic        [VALUE_BITS-1:0]    shadow_value [QUEUE_DEPTH];
  logic signed [PRIORITY_BITS-1:0] shadow_prio  [QUEUE_DEPTH];
  int            shadow_count = 0;
  queue_result_t expected_q[$];
  int            fails = 0;
  int            checked = 0;
  int            full_rejects = 0;
  int            empty_rejects = 0;

  function automatic queue_result_t apply_word(cmd_e cmd, logic [PORT_VALUE_W-1:0] value,
                                               logic signed [PORT_PRIO_W-1:0] prio);
    queue_result_t r;
    int pos;
    r.pulled_value = '0;
    r.pulled_valid = 1'b0;
    r.status       = STATUS_OK;
    if (cmd == CMD_INSERT) begin
      if (shadow_count >= QUEUE_DEPTH) begin
        r.status = STATUS_FULL;
      end else begin
        // new entry goes behind every entry of equal or higher priority
        pos = shadow_count;
        while (pos > 0 && shadow_prio[pos-1] < prio) begin
          shadow_value[pos] = shadow_value[pos-1];
          shadow_prio[pos]  = shadow_prio[pos-1];
          pos--;
        end
        shadow_value[pos] = value;
        shadow_prio[pos]  = prio;
        shadow_count++;
      end
    end else if (shadow_count == 0) begin
      r.status = STATUS_EMPTY;
    end else begin
      r.pulled_value = shadow_value[0];
      r.pulled_valid = 1'b1;
      for (int i = 1; i < shadow_count; i++) begin
        shadow_value[i-1] = shadow_value[i];
        shadow_prio[i-1]  = shadow_prio[i];
      end
      shadow_count--;
    end
    r.head_value  = (shadow_count > 0) ? shadow_value[0] : '0;
    r.entry_total = TOTAL_W'(shadow_count);
    r.queue_empty = (shadow_count == 0);
    r.queue_full  = (shadow_count == QUEUE_DEPTH);
    return r;
  endfunction

  task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%t: %s mismatch, expected %h, actual %h", $realtime, field, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    queue_result_t want;
    if (!rst_ni) begin
      shadow_count = 0;
      expected_q.delete();
    end else begin
      // result first: a word taken on the same edge belongs behind it
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $display("%t: result word with nothing expected, actual head %h total %0d",
                   $realtime, head_value_i, entry_total_i);
          fails++;
        end else begin
          want = expected_q.pop_front();
          compare_field("pulled_value", want.pulled_value, pulled_value_i);
          compare_field("pulled_valid", 32'(want.pulled_valid), 32'(pulled_valid_i));
          compare_field("status", 32'(want.status), 32'(status_i));
          compare_field("head_value", want.head_value, head_value_i);
          compare_field("entry_total", 32'(want.entry_total), 32'(entry_total_i));
          compare_field("queue_empty", 32'(want.queue_empty), 32'(queue_empty_i));
          compare_field("queue_full", 32'(want.queue_full), 32'(queue_full_i));
          checked++;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        want = apply_word(cmd_e'(command_i), item_value_i, item_priority_i);
        if (want.status == STATUS_FULL) full_rejects++;
        if (want.status == STATUS_EMPTY) empty_rejects++;
        expected_q.push_back(want);
      end
    end
    fail_count_o    <= fails;
    pending_o       <= expected_q.size();
    checked_o       <= checked;
    full_rejects_o  <= full_rejects;
    empty_rejects_o <= empty_rejects;
  end

endmodule

// ===== verif/tb.sv =====
// Testbench top for the priority queue: clock, reset, word stimulus, stall patterns and verdict.
`timescale 1ns / 1ps
module tb;
  import sapq_pkg::*;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          command = CMD_INSERT;
  logic        [PORT_VALUE_W-1:0] item_value = '0;
  logic signed [PORT_PRIO_W-1:0]  item_priority = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic        [PORT_VALUE_W-1:0] pulled_value;
  logic                          pulled_valid;
  logic        [1:0]              status;
  logic        [PORT_VALUE_W-1:0] head_value;
  logic        [TOTAL_W-1:0]      entry_total;
  logic                          queue_empty;
  logic                          queue_full;

  int fail_count, pending, checked, full_rejects, empty_rejects;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int n_insert = 0;
  int n_pull = 0;
  int tx_pct_by_phase [3] = '{34, 55, 0};
  int rx_pct_by_phase [3] = '{55, 34, 0};

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  sorted_array_priority_queue dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .command_i      (command),
    .item_value_i   (item_value),
    .item_priority_i(item_priority),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .pulled_value_o (pulled_value),
    .pulled_valid_o (pulled_valid),
    .status_o       (status),
    .head_value_o   (head_value),
    .entry_total_o  (entry_total),
    .queue_empty_o  (queue_empty),
    .queue_full_o   (queue_full)
  );

  sapq_checker queue_watch (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .command_i      (command),
    .item_value_i   (item_value),
    .item_priority_i(item_priority),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .pulled_value_i (pulled_value),
    .pulled_valid_i (pulled_valid),
    .status_i       (status),
    .head_value_i   (head_value),
    .entry_total_i  (entry_total),
    .queue_empty_i  (queue_empty),
    .queue_full_i   (queue_full),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .checked_o      (checked),
    .full_rejects_o (full_rejects),
    .empty_rejects_o(empty_rejects)
  );

  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  task automatic send_word(cmd_e cmd, logic [PORT_VALUE_W-1:0] value,
                           logic signed [PORT_PRIO_W-1:0] prio);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid      <= 1'b1;
    command       <= cmd;
    item_value    <= value;
    item_priority <= prio;
    do @(posedge clk_i); while (in_stall);
    if (cmd == CMD_INSERT) n_insert++;
    else n_pull++;
  endtask

  // hold off the sender until every expected result word is back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // most bursts lean toward filling or draining so full and empty both come up often
  task automatic random_words(int count);
    int left;
    int burst;
    int insert_pct;
    logic signed [PORT_PRIO_W-1:0] prio;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(40, 8);
      case ($urandom_range(2))
        0:       insert_pct = 75;
        1:       insert_pct = 25;
        default: insert_pct = 50;
      endcase
      for (int k = 0; k < burst && left > 0; k++) begin
        case ($urandom_range(3))
          0: begin
            // narrow band, lots of ties
            prio = PORT_PRIO_W'($urandom_range(3));
            prio = prio - 16'sd2;
          end
          1:       prio = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
          default: prio = PORT_PRIO_W'($urandom);
        endcase
        send_word(($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_PULL, $urandom, prio);
        left--;
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(CMD_PULL, 32'hffff_ffff, 16'sh7fff);      // pull on empty
    send_word(CMD_INSERT, 32'hffff_ffff, 16'sh8000);    // lowest priority
    send_word(CMD_INSERT, 32'h0000_0000, 16'sh7fff);    // highest priority
    for (int k = 1; k <= 4; k++) send_word(CMD_INSERT, k, 16'sd0);  // ties leave FIFO
    send_word(CMD_INSERT, 32'h5555_5555, -16'sd1);
    send_word(CMD_INSERT, 32'haaaa_aaaa, 16'sd1);
    for (int k = 9; k <= 16; k++) send_word(CMD_INSERT, 32'h100 + k, 16'(k % 3));
    send_word(CMD_INSERT, 32'hdead_beef, 16'sh7fff);    // insert on full
    repeat (5) send_word(CMD_PULL, $urandom, PORT_PRIO_W'($urandom));
    drain_results();

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = tx_pct_by_phase[ph];
      rx_idle_pct = rx_pct_by_phase[ph];
      random_words(470);
      drain_results();
    end
    rx_idle_pct = 0;
    repeat (5) @(posedge clk_i);

    $display("Sent %0d inserts and %0d pulls under three stall patterns; %0d results checked.",
             n_insert, n_pull, checked);
    $display("Rejected words: %0d inserts on full, %0d pulls on empty.",
             full_rejects, empty_rejects);
    if (fail_count == 0 && pending == 0) begin
      $display("** sorted_array_priority_queue: PASSED **");
    end else begin
      $display("** sorted_array_priority_queue: FAILED **");
    end
    $finish;
  end

  initial begin
    #400_000;
    $display("Run timed out with %0d result words outstanding.", pending);
    $display("** sorted_array_priority_queue: FAILED **");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/sapq_pkg.sv
rtl/sapq_cell.sv
rtl/sorted_array_priority_queue.sv
verif/sapq_checker.sv
verif/tb.sv
